FILE: src/edss_pkg.sv
// ----------------------------------------------------------------------------
// edss_pkg: shared types and constants for the electronic differential
// Field widths, register indexes and reset values, and the fixed-point sine
// and cosine series used to build the tangent table at elaboration.
// ----------------------------------------------------------------------------
package edss_pkg;

	localparam int SPEED_W    = 22;
	localparam int STEER_W    = 15;
	localparam int FACTOR_W   = 16;
	localparam int LIMIT_W    = 21;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int TAN_W      = 18;
	localparam int FRAC_W     = 13;

	// Road wheel angle saturation in 1/64 degree (75 degrees)
	localparam int MAX_ANGLE = 4800;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] TAN_SAT = 64'd262143;

	// Output magnitude limits of the 22 bit signed range
	localparam int OUT_POS_MAX = 2097151;
	localparam int OUT_NEG_MAG = 2097152;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEER_RATIO   = 8'd0,
		CFG_TRACK_OVER_WB = 8'd1,
		CFG_GEAR_RATIO    = 8'd2,
		CFG_SPEED_LIMIT   = 8'd3
	} cfg_index_t;

	localparam logic [FACTOR_W-1:0] STEER_RATIO_RST = 16'd16384;
	localparam logic [FACTOR_W-1:0] TRACK_OVER_WB_RST = 16'd12288;
	localparam logic [FACTOR_W-1:0] GEAR_RATIO_RST = 16'd1024;
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 21'd0;

	// Series term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
	localparam logic [63:0] SIN_DIV [9] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
	};
	localparam logic [63:0] COS_DIV [9] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
	};

	// Sine of a Q30 angle in radians, Q30 result
	function automatic longint sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		longint      s;
		x2 = (x * x) >> 30;
		s  = longint'(x);
		t  = x;
		for (int n = 1; n <= 9; n++) begin
			t = ((t * x2) >> 30) / SIN_DIV[n-1];
			if ((n & 1) == 1) s = s - longint'(t);
			else s = s + longint'(t);
		end
		return s;
	endfunction

	// Cosine of a Q30 angle in radians, Q30 result
	function automatic longint cos_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		longint      c;
		x2 = (x * x) >> 30;
		c  = longint'(64'd1 << 30);
		t  = 64'd1 << 30;
		for (int n = 1; n <= 9; n++) begin
			t = ((t * x2) >> 30) / COS_DIV[n-1];
			if ((n & 1) == 1) c = c - longint'(t);
			else c = c + longint'(t);
		end
		return c;
	endfunction

endpackage

FILE: src/edss_if.sv
// ----------------------------------------------------------------------------
// edss_if: valid/ready channels of the electronic differential
// Command channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface edss_cmd_if;
	logic                                valid;
	logic                                ready;
	logic signed [edss_pkg::SPEED_W-1:0] base_speed;
	logic signed [edss_pkg::STEER_W-1:0] steering_angle;

	modport source (output valid, output base_speed, output steering_angle, input ready);
	modport sink (input valid, input base_speed, input steering_angle, output ready);
endinterface

interface edss_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [edss_pkg::SPEED_W-1:0] front_left_speed;
	logic signed [edss_pkg::SPEED_W-1:0] front_right_speed;
	logic signed [edss_pkg::SPEED_W-1:0] rear_left_speed;
	logic signed [edss_pkg::SPEED_W-1:0] rear_right_speed;

	modport source (
		output valid, output front_left_speed, output front_right_speed,
		output rear_left_speed, output rear_right_speed, input ready
	);
	modport sink (
		input valid, input front_left_speed, input front_right_speed,
		input rear_left_speed, input rear_right_speed, output ready
	);
endinterface

interface edss_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [edss_pkg::CFG_IDX_W-1:0]    index;
	logic [edss_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/electronic_differential_speed_split.sv
// ----------------------------------------------------------------------------
// electronic_differential_speed_split: Ackermann speed split for four motors
// Throughput: one item per cycle while the result channel is ready; the
// fourteen register stages lie in line (ten here, two in each of the two
// constant dividers) with no loop between items.
// Reset: configuration and valid registers return to their defaults and the
// pipeline empties; no clearing pass, the tangent table is constant.
// ----------------------------------------------------------------------------
module electronic_differential_speed_split #(
	parameter int TAN_TABLE_DEPTH = 256,
	parameter int SPEED_FRAC_BITS = 10
) (
	input logic         clk,
	input logic         arst_n,
	edss_cmd_if.sink    cmd,
	edss_res_if.source  result,
	edss_cfg_if.sink    cfg
);

	localparam int SPEED_W = edss_pkg::SPEED_W;
	localparam int TAN_W   = edss_pkg::TAN_W;
	localparam int FRAC_W  = edss_pkg::FRAC_W;
	localparam int SPAN    = TAN_TABLE_DEPTH - 1;
	localparam int IDX_W   = $clog2(TAN_TABLE_DEPTH);
	localparam int POS_W   = $clog2(edss_pkg::MAX_ANGLE * SPAN + 1);
	localparam int P1_W    = SPEED_W + edss_pkg::FACTOR_W;
	localparam int P1_SPLIT = P1_W / 2;
	localparam int PP_W    = P1_SPLIT + TAN_W;
	localparam int PROD_W  = P1_W + TAN_W;
	localparam int HALF_SHIFT = 31;
	localparam int HMAG_W  = PROD_W - HALF_SHIFT;
	localparam int SIDE_W  = HMAG_W + 2;
	localparam int MIX_W   = SIDE_W - 1;
	localparam int MOT_P_W = MIX_W + edss_pkg::FACTOR_W;
	localparam int MOT_W   = MOT_P_W - 8;
	localparam int LIM_W   = 27;
	localparam int MB_W    = TAN_W + FRAC_W;

	// Default limit: 6000 rpm = 200*pi rad/s, rounded to the speed scale
	localparam logic [63:0] DEF_LIM_FULL =
		(64'd200 * edss_pkg::PI_Q30 + (64'd1 << (29 - SPEED_FRAC_BITS)))
		>> (30 - SPEED_FRAC_BITS);

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic                      half_neg;
		logic [P1_W-1:0]           p1;
	} front_t;

	typedef struct packed {
		logic [TAN_W-1:0] t0;
		front_t           f;
	} mid_t;

	// ------------------------------------------------------------------
	// Configuration registers; writes beyond the list are dropped
	// ------------------------------------------------------------------
	logic [edss_pkg::FACTOR_W-1:0] steer_ratio_q;
	logic [edss_pkg::FACTOR_W-1:0] track_over_wb_q;
	logic [edss_pkg::FACTOR_W-1:0] gear_ratio_q;
	logic [edss_pkg::LIMIT_W-1:0]  speed_limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_ratio_q   <= edss_pkg::STEER_RATIO_RST;
			track_over_wb_q <= edss_pkg::TRACK_OVER_WB_RST;
			gear_ratio_q    <= edss_pkg::GEAR_RATIO_RST;
			speed_limit_q   <= edss_pkg::SPEED_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				edss_pkg::CFG_STEER_RATIO: begin
					steer_ratio_q <= cfg.data[edss_pkg::FACTOR_W-1:0];
				end
				edss_pkg::CFG_TRACK_OVER_WB: begin
					track_over_wb_q <= cfg.data[edss_pkg::FACTOR_W-1:0];
				end
				edss_pkg::CFG_GEAR_RATIO: begin
					gear_ratio_q <= cfg.data[edss_pkg::FACTOR_W-1:0];
				end
				edss_pkg::CFG_SPEED_LIMIT: begin
					speed_limit_q <= cfg.data[edss_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tangent table, built at elaboration: entry k holds tan(k*75deg/SPAN)
	// in Q.16, from the Q30 series. Constant logic, read at two addresses.
	// ------------------------------------------------------------------
	logic [TAN_W-1:0] tan_rom [TAN_TABLE_DEPTH];

	for (genvar k = 0; k < TAN_TABLE_DEPTH; k++) begin : g_tan
		localparam logic [63:0] X =
			(64'(k) * 64'd5 * edss_pkg::PI_Q30 + 64'd6 * 64'(SPAN)) / (64'd12 * 64'(SPAN));
		localparam longint S = edss_pkg::sin_q30(X);
		localparam longint C = edss_pkg::cos_q30(X);
		localparam logic [63:0] SU = S;
		localparam logic [63:0] CU = C;
		localparam logic [63:0] TV = (S <= 0) ? 64'd0 :
			(C <= 0) ? edss_pkg::TAN_SAT : ((SU << 16) / CU);
		assign tan_rom[k] = TV[TAN_W-1:0];
	end

	// ------------------------------------------------------------------
	// Handshake: each stage advances when empty or when the next advances,
	// so bubbles close up and a stall holds every item in place.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;
	logic a_in_ready, a_out_valid, b_in_ready, b_out_valid;

	assign en_s10 = !v_s10 || result.ready;
	assign en_s9  = !v_s9 || en_s10;
	assign en_s8  = !v_s8 || en_s9;
	assign en_s7  = !v_s7 || en_s8;
	assign en_s6  = !v_s6 || en_s7;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || b_in_ready;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || a_in_ready;
	assign en_s1  = !v_s1 || en_s2;
	assign cmd.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= cmd.valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= a_out_valid;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= b_out_valid;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: magnitudes, road wheel angle and speed times track ratio
	// ------------------------------------------------------------------
	logic                        speed_neg, steer_neg;
	logic [SPEED_W-1:0]          smag;
	logic [edss_pkg::STEER_W-1:0] amag;
	logic [30:0]                 ang_prod;
	logic [14:0]                 ang_raw;
	logic [FRAC_W-1:0]           angle_w;
	logic [P1_W-1:0]             p1_w;

	logic [FRAC_W-1:0] angle_s1;
	front_t            front_s1;

	assign speed_neg = cmd.base_speed < 0;
	assign steer_neg = cmd.steering_angle < 0;
	assign smag = speed_neg ? SPEED_W'(-cmd.base_speed) : SPEED_W'(cmd.base_speed);
	assign amag = steer_neg ? edss_pkg::STEER_W'(-cmd.steering_angle) :
		edss_pkg::STEER_W'(cmd.steering_angle);
	assign ang_prod = 31'(amag) * 31'(steer_ratio_q);
	assign ang_raw  = ang_prod[30:16];
	// Saturate the road wheel angle at 75 degrees
	assign angle_w  = (ang_raw > 15'(edss_pkg::MAX_ANGLE)) ? FRAC_W'(edss_pkg::MAX_ANGLE) :
		ang_raw[FRAC_W-1:0];
	assign p1_w = P1_W'(smag) * P1_W'(track_over_wb_q);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			angle_s1          <= angle_w;
			front_s1.speed    <= cmd.base_speed;
			front_s1.half_neg <= speed_neg != steer_neg;
			front_s1.p1       <= p1_w;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: table position = angle * SPAN, later split by 4800
	// ------------------------------------------------------------------
	logic [POS_W-1:0] pos_s2;
	front_t           front_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pos_s2   <= POS_W'(angle_s1) * POS_W'(SPAN);
			front_s2 <= front_s1;
		end
	end

	// Position into table index (quotient) and interpolation fraction (remainder)
	logic [POS_W-1:0]    a_quo;
	logic [FRAC_W-1:0]   a_rem;
	logic [$bits(front_t)-1:0] a_sb;

	edss_cdiv #(
		.NUM_W (POS_W),
		.DIV   (edss_pkg::MAX_ANGLE),
		.SB_W  ($bits(front_t))
	) u_div_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (a_in_ready),
		.num       (pos_s2),
		.in_sb     (front_s2),
		.out_valid (a_out_valid),
		.out_ready (en_s3),
		.quo       (a_quo),
		.rem       (a_rem),
		.out_sb    (a_sb)
	);

	// ------------------------------------------------------------------
	// Stage 3: read the two neighbouring table entries
	// ------------------------------------------------------------------
	logic [IDX_W-1:0] idx0, idx1;
	logic [TAN_W-1:0] t0_w, t1_w;

	logic [TAN_W-1:0]  t0_s3, dt_s3;
	logic [FRAC_W-1:0] frac_s3;
	front_t            front_s3;

	assign idx0 = a_quo[IDX_W-1:0];
	// The last entry is only reached with a zero fraction: hold the index there
	assign idx1 = (idx0 == IDX_W'(SPAN)) ? idx0 : idx0 + IDX_W'(1);
	assign t0_w = tan_rom[idx0];
	assign t1_w = tan_rom[idx1];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			t0_s3    <= t0_w;
			dt_s3    <= (t1_w < t0_w) ? '0 : t1_w - t0_w;
			frac_s3  <= a_rem;
			front_s3 <= a_sb;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: step times fraction, divided by 4800 next
	// ------------------------------------------------------------------
	logic [MB_W-1:0] m_s4;
	mid_t            mid_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			m_s4     <= MB_W'(dt_s3) * MB_W'(frac_s3);
			mid_s4.t0 <= t0_s3;
			mid_s4.f  <= front_s3;
		end
	end

	logic [MB_W-1:0]           b_quo;
	logic [$bits(mid_t)-1:0]   b_sb;
	mid_t                      mid_b;

	edss_cdiv #(
		.NUM_W (MB_W),
		.DIV   (edss_pkg::MAX_ANGLE),
		.SB_W  ($bits(mid_t))
	) u_div_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (b_in_ready),
		.num       (m_s4),
		.in_sb     (mid_s4),
		.out_valid (b_out_valid),
		.out_ready (en_s5),
		.quo       (b_quo),
		.rem       (),
		.out_sb    (b_sb)
	);

	assign mid_b = b_sb;

	// ------------------------------------------------------------------
	// Stage 5: interpolated tangent
	// ------------------------------------------------------------------
	logic [TAN_W-1:0] tanv_s5;
	front_t           front_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			tanv_s5  <= mid_b.t0 + b_quo[TAN_W-1:0];
			front_s5 <= mid_b.f;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: wide product split into two partial products
	// ------------------------------------------------------------------
	logic [PP_W-1:0]           pl_s6, ph_s6;
	logic signed [SPEED_W-1:0] speed_s6;
	logic                      half_neg_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			pl_s6       <= PP_W'(front_s5.p1[P1_SPLIT-1:0]) * PP_W'(tanv_s5);
			ph_s6       <= PP_W'(front_s5.p1[P1_W-1:P1_SPLIT]) * PP_W'(tanv_s5);
			speed_s6    <= front_s5.speed;
			half_neg_s6 <= front_s5.half_neg;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: half difference magnitude
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]         prod_w;
	logic [HMAG_W-1:0]         hmag_s7;
	logic signed [SPEED_W-1:0] speed_s7;
	logic                      half_neg_s7;

	assign prod_w = (PROD_W'(ph_s6) << P1_SPLIT) + PROD_W'(pl_s6);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			hmag_s7     <= prod_w[PROD_W-1:HALF_SHIFT];
			speed_s7    <= speed_s6;
			half_neg_s7 <= half_neg_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: add half for the left side, subtract it for the right
	// ------------------------------------------------------------------
	logic signed [SIDE_W-1:0] half_w;
	logic signed [SIDE_W-1:0] speed_x;
	logic signed [SIDE_W-1:0] left_w, right_w;
	logic signed [SIDE_W-1:0] left_s8, right_s8;

	assign half_w  = half_neg_s7 ? -$signed({2'b00, hmag_s7}) : $signed({2'b00, hmag_s7});
	assign speed_x = SIDE_W'(speed_s7);
	assign left_w  = speed_x + half_w;
	assign right_w = speed_x - half_w;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			left_s8  <= left_w;
			right_s8 <= right_w;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: magnitudes times gear ratio, truncated toward zero
	// ------------------------------------------------------------------
	logic [MIX_W-1:0]   lmag, rmag;
	logic [MOT_P_W-1:0] lmot_p, rmot_p;
	logic [MOT_W-1:0]   lmot_s9, rmot_s9;
	logic               lneg_s9, rneg_s9;

	assign lmag = left_s8 < 0 ? MIX_W'(-left_s8) : MIX_W'(left_s8);
	assign rmag = right_s8 < 0 ? MIX_W'(-right_s8) : MIX_W'(right_s8);
	assign lmot_p = MOT_P_W'(lmag) * MOT_P_W'(gear_ratio_q);
	assign rmot_p = MOT_P_W'(rmag) * MOT_P_W'(gear_ratio_q);

	always_ff @(posedge clk) begin
		if (en_s9) begin
			lmot_s9 <= lmot_p[MOT_P_W-1:8];
			rmot_s9 <= rmot_p[MOT_P_W-1:8];
			lneg_s9 <= left_s8 < 0;
			rneg_s9 <= right_s8 < 0;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: clamp to the speed limit and to the output range; this
	// is the output register, both wheels of a side share one value
	// ------------------------------------------------------------------
	logic [LIM_W-1:0] lim;
	logic signed [SPEED_W-1:0] left_s10, right_s10;

	assign lim = (speed_limit_q != '0) ? LIM_W'(speed_limit_q) : DEF_LIM_FULL[LIM_W-1:0];

	function automatic logic [SPEED_W-1:0] clamp_out(
		input logic [MOT_W-1:0] mag,
		input logic             neg,
		input logic [LIM_W-1:0] limit
	);
		logic [MOT_W-1:0] cap;
		logic [MOT_W-1:0] c;
		cap = MOT_W'(limit);
		if (neg) begin
			if (cap > MOT_W'(edss_pkg::OUT_NEG_MAG)) cap = MOT_W'(edss_pkg::OUT_NEG_MAG);
		end else begin
			if (cap > MOT_W'(edss_pkg::OUT_POS_MAX)) cap = MOT_W'(edss_pkg::OUT_POS_MAX);
		end
		c = (mag > cap) ? cap : mag;
		return neg ? SPEED_W'(-c) : SPEED_W'(c);
	endfunction

	always_ff @(posedge clk) begin
		if (en_s10) begin
			left_s10  <= clamp_out(lmot_s9, lneg_s9, lim);
			right_s10 <= clamp_out(rmot_s9, rneg_s9, lim);
		end
	end

	assign result.valid             = v_s10;
	assign result.front_left_speed  = left_s10;
	assign result.rear_left_speed   = left_s10;
	assign result.front_right_speed = right_s10;
	assign result.rear_right_speed  = right_s10;

endmodule

FILE: src/edss_cdiv.sv
// ----------------------------------------------------------------------------
// edss_cdiv: two-stage pipelined divider by a constant
// Reciprocal multiply gives a quotient estimate, then one compare and
// subtract corrects it. Carries a sideband word alongside.
// ----------------------------------------------------------------------------
module edss_cdiv #(
	parameter int NUM_W = 25,
	parameter int DIV   = 4800,
	parameter int SB_W  = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [NUM_W-1:0]         num,
	input  logic [SB_W-1:0]          in_sb,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [NUM_W-1:0]         quo,
	output logic [$clog2(DIV)-1:0]   rem,
	output logic [SB_W-1:0]          out_sb
);

	localparam int REM_W = $clog2(DIV);
	localparam int RCP_W = NUM_W - REM_W + 1;
	localparam int PROD_W = NUM_W + RCP_W;
	// 2^NUM_W exceeds every numerator, so the estimate is short by at most one
	localparam logic [63:0] RECIP_FULL = (64'd1 << NUM_W) / DIV;

	logic              v_s1, v_s2;
	logic              en_s1, en_s2;
	logic [PROD_W-1:0] prod;
	logic [RCP_W-1:0]  qe_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [SB_W-1:0]   sb_s1, sb_s2;
	logic [NUM_W-1:0]  qd;
	logic [NUM_W-1:0]  rem_full;
	logic [REM_W:0]    rem_raw;
	logic              corr;
	logic [NUM_W-1:0]  quo_s2;
	logic [REM_W-1:0]  rem_s2;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign prod = PROD_W'(num) * PROD_W'(RECIP_FULL[RCP_W-1:0]);

	assign qd       = NUM_W'(qe_s1) * NUM_W'(DIV);
	assign rem_full = num_s1 - qd;
	assign rem_raw  = rem_full[REM_W:0];
	assign corr     = rem_raw >= (REM_W+1)'(DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			qe_s1  <= prod[NUM_W +: RCP_W];
			num_s1 <= num;
			sb_s1  <= in_sb;
		end
		if (en_s2) begin
			quo_s2 <= NUM_W'(qe_s1) + NUM_W'(corr);
			rem_s2 <= corr ? REM_W'(rem_raw - (REM_W+1)'(DIV)) : rem_raw[REM_W-1:0];
			sb_s2  <= sb_s1;
		end
	end

	assign out_valid = v_s2;
	assign quo       = quo_s2;
	assign rem       = rem_s2;
	assign out_sb    = sb_s2;

endmodule
